FILE: design/pitt_pkg.sv
// Package with constants, types and helpers for the integer-to-text formatter.
`timescale 1ns / 1ps
package pitt_pkg;
	localparam int VALUE_BITS = 16;
	localparam int MAX_WIDTH = 31;
	localparam int OUT_CAP = 32;
	localparam int DIGITS = 16;

	localparam logic [2:0] FUNC_SDEC = 3'd0;
	localparam logic [2:0] FUNC_UDEC = 3'd1;
	localparam logic [2:0] FUNC_OCT = 3'd2;
	localparam logic [2:0] FUNC_HEXL = 3'd3;
	localparam logic [2:0] FUNC_HEXU = 3'd4;
	localparam logic [2:0] FUNC_BIN = 3'd5;

	localparam logic [1:0] MASK_NONE = 2'd0;
	localparam logic [1:0] MASK_BYTE = 2'd1;
	localparam logic [1:0] MASK_HALF = 2'd2;

	localparam logic [6:0] CH_ZERO = 7'h30;
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_MINUS = 7'h2d;

	typedef struct packed {
		logic [15:0] value;
		logic [2:0] func;
		logic [1:0] size_mask;
		logic [4:0] field_width;
		logic left_justify;
		logic zero_fill;
	} in_item_t;

	typedef struct packed {
		logic [6:0] character;
		logic last;
	} out_item_t;

	// Digit character for a 4-bit digit value.
	function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
		logic [6:0] c;
		begin
			if (d < 4'd10) c = CH_ZERO + {3'd0, d};
			else if (upper) c = 7'h41 + {3'd0, d - 4'd10};
			else c = 7'h61 + {3'd0, d - 4'd10};
			return c;
		end
	endfunction
endpackage

FILE: design/pitt_if.sv
// Valid/ready channel interfaces for the formatter.
`timescale 1ns / 1ps
interface pitt_in_if;
	logic valid;
	logic ready;
	pitt_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pitt_out_if;
	logic valid;
	logic ready;
	pitt_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/padded_integer_to_text.sv
// Top level of the padded integer-to-text formatter.
`timescale 1ns / 1ps
// Formats one 16-bit value as ASCII, one character per output transaction,
// with last set on the final character. An input transaction enters a
// pipeline: stage 1 applies sign and mask, stages 2 to 5 convert to digits
// (decimal takes one double-dabble digit group per stage: four stages of four
// shift steps), stage 6 counts digits and layout. The character serializer then
// sends 1 to 32 characters, one per cycle while the output is ready; the serializer
// sets the rate. The pipeline keeps moving while the serializer drains, holding
// only when its last stage is full.
module padded_integer_to_text (
	input logic clk,
	input logic arst_n,
	pitt_in_if.sink in_ch,
	pitt_out_if.source out_ch
);
	// base code: 0 dec, 1 oct, 2 hex, 3 bin
	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_OCT = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;
	localparam logic [1:0] BASE_BIN = 2'd3;

	// Stage 1: magnitude, base.
	logic v_s1; logic [15:0] mag_s1; logic [1:0] base_s1; logic neg_s1, up_s1;
	logic [4:0] w_s1; logic lj_s1, zf_s1;
	// Decimal conversion stages: bcd with remaining binary.
	logic v_s2, v_s3, v_s4, v_s5;
	logic [19:0] bcd_s2, bcd_s3, bcd_s4, bcd_s5;
	logic [15:0] bin_s2, bin_s3, bin_s4;
	logic [35:0] dd_last;
	logic [1:0] base_s2, base_s3, base_s4, base_s5;
	logic [3:0] misc_s2, misc_s3, misc_s4, misc_s5; // neg,up,lj,zf
	logic [4:0] w_s2, w_s3, w_s4, w_s5;
	// Stage 6: digits ready for serialization.
	logic v_s6; logic [3:0] dig_s6 [pitt_pkg::DIGITS]; logic [4:0] nd_s6;
	logic neg_s6, up_s6, lj_s6, zf_s6; logic [4:0] w_s6;

	logic adv6, adv5, adv4, adv3, adv2, adv1, busy, take;
	assign adv1 = !v_s1 || adv2;
	assign adv2 = !v_s2 || adv3;
	assign adv3 = !v_s3 || adv4;
	assign adv4 = !v_s4 || adv5;
	assign adv5 = !v_s5 || adv6;
	assign adv6 = !v_s6 || take;
	assign in_ch.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv1) v_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (adv1 && in_ch.valid) begin
			logic [15:0] n; logic ng; logic [1:0] b; logic u;
			n = in_ch.data.value; ng = 1'b0;
			b = BASE_DEC; u = 1'b0;
			case (in_ch.data.func)
				pitt_pkg::FUNC_SDEC: if (n[15]) begin n = -n; ng = 1'b1; end
				pitt_pkg::FUNC_UDEC: ;
				pitt_pkg::FUNC_OCT: b = BASE_OCT;
				pitt_pkg::FUNC_HEXL: b = BASE_HEX;
				pitt_pkg::FUNC_HEXU: begin b = BASE_HEX; u = 1'b1; end
				pitt_pkg::FUNC_BIN: b = BASE_BIN;
				default: n = '0;
			endcase
			if (in_ch.data.size_mask == pitt_pkg::MASK_BYTE) n = {8'd0, n[7:0]};
			mag_s1 <= n; neg_s1 <= ng;
			base_s1 <= b; up_s1 <= u;
			w_s1 <= in_ch.data.field_width;
			lj_s1 <= in_ch.data.left_justify; zf_s1 <= in_ch.data.zero_fill;
		end
	end

	// Four double-dabble steps on (bcd,bin).
	function automatic logic [35:0] dd4(input logic [19:0] b, input logic [15:0] x);
		logic [35:0] r;
		begin
			r = {b, x};
			for (int s = 0; s < 4; s++) begin
				for (int k = 0; k < 5; k++)
					if (r[16+4*k +: 4] >= 4'd5) r[16+4*k +: 4] = r[16+4*k +: 4] + 4'd3;
				r = r << 1;
			end
			return r;
		end
	endfunction

	assign dd_last = dd4(bcd_s4, bin_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else begin
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (adv2) begin
			{bcd_s2, bin_s2} <= dd4(20'd0, mag_s1);
			base_s2 <= base_s1; w_s2 <= w_s1;
			misc_s2 <= {neg_s1, up_s1, lj_s1, zf_s1};
		end
		if (adv3) begin
			{bcd_s3, bin_s3} <= dd4(bcd_s2, bin_s2);
			base_s3 <= base_s2; w_s3 <= w_s2; misc_s3 <= misc_s2;
		end
		if (adv4) begin
			{bcd_s4, bin_s4} <= dd4(bcd_s3, bin_s3);
			base_s4 <= base_s3; w_s4 <= w_s3; misc_s4 <= misc_s3;
		end
		if (adv5) begin
			bcd_s5 <= dd_last[35:16];
			base_s5 <= base_s4; w_s5 <= w_s4; misc_s5 <= misc_s4;
		end
	end
	// After 16 shifts the original magnitude is gone from bin; rebuild it for
	// power-of-two bases by carrying it alongside.
	logic [15:0] raw_s2, raw_s3, raw_s4, raw_s5;
	always_ff @(posedge clk) begin
		if (adv2) raw_s2 <= mag_s1;
		if (adv3) raw_s3 <= raw_s2;
		if (adv4) raw_s4 <= raw_s3;
		if (adv5) raw_s5 <= raw_s4;
	end

	// Stage 6: digit list (least significant first) and digit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv6) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (adv6) begin
			logic [4:0] n;
			n = 5'd1;
			for (int k = 0; k < pitt_pkg::DIGITS; k++) begin
				case (base_s5)
					BASE_DEC: dig_s6[k] <= (k < 5) ? bcd_s5[4*(k%5) +: 4] : 4'd0;
					BASE_OCT: dig_s6[k] <= (k < 6) ? {1'b0, 3'((raw_s5 >> (3*k)) & 16'h7)}
						: 4'd0;
					BASE_HEX: dig_s6[k] <= (k < 4) ? raw_s5[4*(k%4) +: 4] : 4'd0;
					default: dig_s6[k] <= {3'd0, raw_s5[k]};
				endcase
				case (base_s5)
					BASE_DEC: if (k < 5 && bcd_s5[4*(k%5) +: 4] != 4'd0) n = 5'(k + 1);
					BASE_OCT: if (k < 6 && ((raw_s5 >> (3*k)) & 16'h7) != 16'd0) n = 5'(k + 1);
					BASE_HEX: if (k < 4 && raw_s5[4*(k%4) +: 4] != 4'd0) n = 5'(k + 1);
					default: if (raw_s5[k]) n = 5'(k + 1);
				endcase
			end
			nd_s6 <= n; w_s6 <= w_s5;
			{neg_s6, up_s6, lj_s6, zf_s6} <= misc_s5;
		end
	end

	// Serializer: position counter over sign, pre-pad, digits, post-pad.
	logic [5:0] pos_q;
	logic [5:0] pre, total, p;
	logic [3:0] di;
	logic [6:0] ch;
	always_comb begin
		pre = (!lj_s6 && w_s6 > nd_s6) ? 6'(w_s6 - nd_s6) : 6'd0;
		total = {5'd0, neg_s6} + ((w_s6 > nd_s6) ? {1'b0, w_s6} : {1'b0, nd_s6});
		p = pos_q;
		di = '0;
		if (neg_s6 && p == 6'd0) ch = pitt_pkg::CH_MINUS;
		else begin
			p = p - {5'd0, neg_s6};
			if (p < pre) ch = zf_s6 ? pitt_pkg::CH_ZERO : pitt_pkg::CH_SPACE;
			else if (p < pre + {1'b0, nd_s6}) begin
				di = 4'(nd_s6 - 5'd1 - 5'(p - pre));
				ch = pitt_pkg::digit_char(dig_s6[di], up_s6);
			end else ch = pitt_pkg::CH_SPACE;
		end
	end
	assign out_ch.valid = v_s6;
	assign out_ch.data.character = ch;
	assign out_ch.data.last = (pos_q + 6'd1 == total);
	assign take = v_s6 && out_ch.ready && out_ch.data.last;
	assign busy = pos_q != 6'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pos_q <= '0;
		else if (v_s6 && out_ch.ready) pos_q <= out_ch.data.last ? 6'd0 : pos_q + 6'd1;
	end

`ifndef SYNTHESIS
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> pos_q < total) else $error("character position past end");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> v_s6) else $error("position counter runs without an item");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !take) |=> v_s6) else $error("item dropped before its last character");
`endif
endmodule
